>>> sv/pmu_cma_pkg.sv
// ----------------------------------------------------------------------------
// pmu_cma_pkg
// Shared widths, event-code field constants and the storage-subsystem shift
// table of the performance-counter mux assigner.
// ----------------------------------------------------------------------------
`default_nettype none

package pmu_cma_pkg;

  localparam int EVENT_W = 24;
  localparam int WORD_W  = 64;
  localparam int CTR_W   = 2;
  localparam int COUNT_W = 3;
  localparam int SEL_W   = 7;
  localparam int UNIT_W  = 4;
  localparam int NUM_CTR = 4;
  localparam int NUM_LANE = 4;
  localparam int NUM_UNIT = 14;

  // unit codes
  localparam logic [UNIT_W-1:0] UNIT_ISU0     = 4'd1;
  localparam logic [UNIT_W-1:0] UNIT_ISU0_ALT = 4'd6;
  localparam logic [UNIT_W-1:0] UNIT_GRS      = 4'd7;
  localparam logic [UNIT_W-1:0] UNIT_MAX      = 4'hc;
  localparam logic [UNIT_W-1:0] UNIT_HI_BYTE  = 4'hc;
  localparam logic [UNIT_W-1:0] UNIT_HI_LANE  = 4'hd;

  // counter select codes
  localparam logic [SEL_W-1:0] SEL_TWEAK_MASK  = 7'h58;
  localparam logic [SEL_W-1:0] SEL_TWEAK_MATCH = 7'h40;
  localparam logic [SEL_W-1:0] SEL_ALT_LANE    = 7'h10;
  localparam logic [SEL_W-1:0] SEL_ADDER_A     = 7'h08;
  localparam logic [SEL_W-1:0] SEL_ADDER_B     = 7'h10;
  localparam logic [SEL_W-1:0] SEL_ADDER_C     = 7'h28;

  localparam logic [2:0] PC_MAX = 3'd4;

  // storage-subsystem select position, chosen by the low select bits
  function automatic logic [5:0] grs_shift(input logic [2:0] sel_lo);
    logic [5:0] sh;
    case (sel_lo)
      3'd0, 3'd1, 3'd2: sh = 6'd46;
      3'd3, 3'd4, 3'd5: sh = 6'd44;
      3'd6:             sh = 6'd41;
      default:          sh = 6'd39;
    endcase
    return sh;
  endfunction

endpackage

`default_nettype wire

>>> sv/pmu_cma_if.sv
// ----------------------------------------------------------------------------
// pmu_cma_if
// Valid/ready channels of the mux assigner: event beats in, result beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pmu_cma_in_if;
  import pmu_cma_pkg::*;

  logic               valid;
  logic               ready;
  logic [EVENT_W-1:0] event_code;
  logic               last_event;

  modport source (output valid, output event_code, output last_event, input ready);
  modport sink   (input valid, input event_code, input last_event, output ready);
endinterface

interface pmu_cma_out_if;
  import pmu_cma_pkg::*;

  logic               valid;
  logic               ready;
  logic               status;
  logic [WORD_W-1:0]  mux_control_word;
  logic               first_counter_cond_enable;
  logic               other_counters_cond_enable;
  logic [CTR_W-1:0]   counter_for_event0;
  logic [CTR_W-1:0]   counter_for_event1;
  logic [CTR_W-1:0]   counter_for_event2;
  logic [CTR_W-1:0]   counter_for_event3;
  logic [COUNT_W-1:0] events_in_set;

  modport source (
    output valid, output status, output mux_control_word,
    output first_counter_cond_enable, output other_counters_cond_enable,
    output counter_for_event0, output counter_for_event1,
    output counter_for_event2, output counter_for_event3,
    output events_in_set, input ready
  );
  modport sink (
    input valid, input status, input mux_control_word,
    input first_counter_cond_enable, input other_counters_cond_enable,
    input counter_for_event0, input counter_for_event1,
    input counter_for_event2, input counter_for_event3,
    input events_in_set, output ready
  );
endinterface

`default_nettype wire

>>> sv/pmu_counter_mux_assigner_top.sv
// ----------------------------------------------------------------------------
// pmu_counter_mux_assigner_top
// Collects a set of event codes and assigns counters and mux selects.
// ----------------------------------------------------------------------------
// Event beats are taken one per cycle while idle and buffered until the beat
// marked last_event. The buffered events are then walked twice through one
// shared event decode: a CHECK step per event for conflict checks (counter
// numbers, byte lanes, unit codes), a MUXSEL step for the unit-mux choice
// and lane selects, and an ASSIGN step per event for counter assignment and
// control-word build, then FINISH loads the result register; events.ready is
// low from the last beat until then. A set with more than EVENT_SLOTS events
// skips the walk and is rejected. Event beats are taken again while the result
// waits to be read; a finished set waits for the result register to empty.
`default_nettype none

module pmu_counter_mux_assigner_top #(
  parameter int EVENT_SLOTS = 4
) (
  input  wire           clk,
  input  wire           rst,
  pmu_cma_in_if.sink    events,
  pmu_cma_out_if.source results
);
  import pmu_cma_pkg::*;

  localparam int IDX_W = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;

  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    MUXSEL,
    ASSIGN,
    FINISH
  } state_t;

  state_t state;

  logic [EVENT_W-1:0] event_store [EVENT_SLOTS];
  logic [COUNT_W-1:0] event_count;
  logic               too_many_events;
  logic [COUNT_W-1:0] idx;
  logic               bad;
  logic [NUM_CTR-1:0] inuse;
  logic [NUM_LANE-1:0] lane_valid;
  logic [UNIT_W-1:0]  lane_unit [NUM_LANE];
  logic [NUM_UNIT-1:0] used;
  logic [WORD_W-1:0]  word;
  logic [CTR_W-1:0]   ctr [NUM_CTR];

  logic               out_valid;
  logic               out_status;
  logic [WORD_W-1:0]  out_word;
  logic               out_first_en;
  logic               out_other_en;
  logic [CTR_W-1:0]   out_ctr [NUM_CTR];
  logic [COUNT_W-1:0] out_count;

  // ---------------------------------------------------------------- beat intake
  logic               in_fire;
  logic               store_ok;
  logic [COUNT_W-1:0] count_next;
  logic               too_many_next;

  assign events.ready = (state == IDLE);
  assign in_fire      = events.valid && events.ready;
  assign store_ok     = (event_count < COUNT_W'(EVENT_SLOTS));

  always_comb begin
    count_next    = event_count;
    too_many_next = too_many_events;
    if (store_ok) begin
      count_next = event_count + 3'd1;
    end else begin
      too_many_next = 1'b1;
    end
  end

  // ---------------------------------------------------------------- shared per-event step
  logic [EVENT_W-1:0] cur;
  logic [3:0]         cur_pc;
  logic [UNIT_W-1:0]  cur_unit;
  logic [2:0]         cur_byte;
  logic               cur_bus;
  logic [SEL_W-1:0]   cur_sel;

  assign cur      = event_store[idx[IDX_W-1:0]];
  assign cur_pc   = cur[23:20];
  assign cur_unit = cur[19:16];
  assign cur_byte = cur[14:12];
  assign cur_bus  = cur[7];
  assign cur_sel  = cur[6:0];

  // check pass
  logic                chk_err;
  logic [NUM_CTR-1:0]  chk_inuse;
  logic [NUM_LANE-1:0] chk_lane_valid;
  logic [UNIT_W-1:0]   chk_lane_unit [NUM_LANE];
  logic [NUM_UNIT-1:0] chk_used;
  logic [1:0]          chk_pc;
  logic [UNIT_W-1:0]   chk_unit;
  logic [1:0]          chk_lane;

  always_comb begin
    chk_err        = 1'b0;
    chk_inuse      = inuse;
    chk_lane_valid = lane_valid;
    chk_lane_unit  = lane_unit;
    chk_used       = used;
    chk_pc         = 2'(cur_pc - 4'd1);
    chk_unit       = cur_unit;
    chk_lane       = cur_byte[1:0];
    if (cur_pc != 4'd0) begin
      if (cur_pc > 4'(PC_MAX) || inuse[chk_pc]) begin
        chk_err = 1'b1;
      end else begin
        chk_inuse[chk_pc] = 1'b1;
      end
    end
    if (cur_bus) begin
      if (cur_unit > UNIT_MAX) begin
        chk_err = 1'b1;
      end else begin
        if (cur_unit == UNIT_ISU0_ALT) begin
          chk_unit = UNIT_ISU0;
        end
        if (cur_byte[2]) begin
          if (chk_unit != UNIT_HI_BYTE) begin
            chk_err = 1'b1;
          end
          chk_unit = UNIT_HI_LANE;
        end
        if (lane_valid[chk_lane] && lane_unit[chk_lane] != chk_unit) begin
          chk_err = 1'b1;
        end
        chk_lane_valid[chk_lane] = 1'b1;
        chk_lane_unit[chk_lane]  = chk_unit;
        chk_used[chk_unit]       = 1'b1;
      end
    end
  end

  // unit-mux choice and byte-lane selects
  logic                mux_err;
  logic [NUM_UNIT-1:0] mux_used;
  logic [WORD_W-1:0]   mux_word;
  logic [UNIT_W-1:0]   mux_lane_unit;

  always_comb begin
    mux_used = used;
    mux_word = '0;
    mux_err  = 1'b0;
    mux_lane_unit = '0;
    // isu0 moves to the second mux when it shares the first with others
    if (used[1] && (used[0] || used[2] || used[3])) begin
      mux_used[6] = 1'b1;
      mux_used[1] = 1'b0;
    end
    if ((mux_used[3:0] & (mux_used[3:0] - 4'd1)) != 4'd0) begin
      mux_err = 1'b1;
    end
    if ((mux_used[7:4] & (mux_used[7:4] - 4'd1)) != 4'd0) begin
      mux_err = 1'b1;
    end
    for (int u = 0; u < 4; u++) begin
      if (mux_used[u]) begin
        mux_word[63:62] = mux_word[63:62] | 2'(u);
      end
      if (mux_used[u + 4]) begin
        mux_word[61:60] = mux_word[61:60] | 2'(u);
      end
    end
    for (int l = 0; l < NUM_LANE; l++) begin
      if (lane_valid[l]) begin
        mux_lane_unit = lane_unit[l];
        if (mux_lane_unit == UNIT_ISU0 && mux_used[6]) begin
          mux_lane_unit = UNIT_ISU0_ALT;
        end else if (mux_lane_unit == UNIT_HI_LANE) begin
          mux_word[59 - l] = 1'b1;
        end
        mux_word[55 - 2*l -: 2] = mux_lane_unit[3:2];
      end
    end
  end

  // assign pass
  logic               asg_err;
  logic [NUM_CTR-1:0] asg_inuse;
  logic [1:0]         asg_pc;
  logic               asg_found;
  logic [SEL_W-1:0]   asg_sel;
  logic [WORD_W-1:0]  asg_word;
  logic [4:0]         asg_sel_sh;

  always_comb begin
    asg_err   = 1'b0;
    asg_inuse = inuse;
    asg_pc    = 2'(cur_pc - 4'd1);
    asg_found = 1'b0;
    asg_sel   = cur_sel;
    asg_word  = word;
    if (cur_pc == 4'd0) begin
      // lowest free counter
      for (int c = NUM_CTR - 1; c >= 0; c--) begin
        if (!inuse[c]) begin
          asg_pc    = 2'(c);
          asg_found = 1'b1;
        end
      end
      if (!asg_found) begin
        asg_err = 1'b1;
      end
      asg_inuse[asg_pc] = 1'b1;
    end else if (cur_bus && cur_byte[1] &&
                 (cur_sel == SEL_ADDER_A || cur_sel == SEL_ADDER_B ||
                  cur_sel == SEL_ADDER_C)) begin
      asg_word = asg_word | (WORD_W'(1) << (6'd35 - 6'(asg_pc)));
    end
    if (cur_bus && cur_unit == UNIT_GRS) begin
      asg_word = asg_word | (WORD_W'(cur[10:8]) << grs_shift(cur_sel[2:0]));
    end
    // alternate byte lane when the low byte bit and the counter pair differ
    if ((cur_sel & SEL_TWEAK_MASK) == SEL_TWEAK_MATCH && cur_byte[0] != asg_pc[1]) begin
      asg_sel = asg_sel | SEL_ALT_LANE;
    end
    asg_sel_sh = 5'd25 - {asg_pc, 3'b000};
    asg_word   = asg_word | (WORD_W'(asg_sel) << asg_sel_sh);
  end

  // ---------------------------------------------------------------- sequencer
  logic out_free;
  logic last_step;

  assign out_free  = !out_valid || results.ready;
  assign last_step = (idx == event_count - 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= IDLE;
      event_count     <= '0;
      too_many_events <= 1'b0;
      idx             <= '0;
      out_valid       <= 1'b0;
    end else begin
      // a beat taken while a new set finishes is replaced in the same cycle
      if (out_valid && results.ready && state != FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_fire) begin
            if (store_ok) begin
              event_store[event_count[IDX_W-1:0]] <= events.event_code;
            end
            event_count     <= count_next;
            too_many_events <= too_many_next;
            if (events.last_event) begin
              idx        <= '0;
              bad        <= too_many_next;
              inuse      <= '0;
              lane_valid <= '0;
              used       <= '0;
              word       <= '0;
              for (int k = 0; k < NUM_CTR; k++) begin
                ctr[k]       <= '0;
                lane_unit[k] <= '0;
              end
              state <= too_many_next ? FINISH : CHECK;
            end
          end
        end
        CHECK: begin
          bad        <= bad | chk_err;
          inuse      <= chk_inuse;
          lane_valid <= chk_lane_valid;
          lane_unit  <= chk_lane_unit;
          used       <= chk_used;
          if (last_step) begin
            idx   <= '0;
            state <= MUXSEL;
          end else begin
            idx <= idx + 3'd1;
          end
        end
        MUXSEL: begin
          bad   <= bad | mux_err;
          word  <= mux_word;
          state <= ASSIGN;
        end
        ASSIGN: begin
          bad              <= bad | asg_err;
          inuse            <= asg_inuse;
          word             <= asg_word;
          ctr[idx[1:0]]    <= asg_pc;
          if (last_step) begin
            state <= FINISH;
          end else begin
            idx <= idx + 3'd1;
          end
        end
        FINISH: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            out_status   <= bad;
            out_word     <= bad ? '0 : word;
            out_first_en <= !bad && inuse[0];
            out_other_en <= !bad && (inuse[3:1] != 3'd0);
            for (int k = 0; k < NUM_CTR; k++) begin
              out_ctr[k] <= bad ? '0 : ctr[k];
            end
            out_count       <= event_count;
            event_count     <= '0;
            too_many_events <= 1'b0;
            state           <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign results.valid                      = out_valid;
  assign results.status                     = out_status;
  assign results.mux_control_word           = out_word;
  assign results.first_counter_cond_enable  = out_first_en;
  assign results.other_counters_cond_enable = out_other_en;
  assign results.counter_for_event0         = out_ctr[0];
  assign results.counter_for_event1         = out_ctr[1];
  assign results.counter_for_event2         = out_ctr[2];
  assign results.counter_for_event3         = out_ctr[3];
  assign results.events_in_set              = out_count;

  // ---------------------------------------------------------------- assertions
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status |-> out_word == '0 && !out_first_en && !out_other_en)
    else $error("rejected set carries a non-zero result");

  a_accept_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_status |->
      out_count != 3'd0 && out_count <= COUNT_W'(EVENT_SLOTS))
    else $error("accepted set with an impossible event count");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == CHECK || state == ASSIGN) |-> idx < event_count)
    else $error("event walk beyond the stored events");

  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    in_fire && events.last_event |=> state != IDLE)
    else $error("closing beat did not start the set");

  a_result_loads: assert property (@(posedge clk) disable iff (rst)
    state == FINISH && out_free |=> out_valid && state == IDLE && event_count == '0)
    else $error("finished set not loaded into the result register");

endmodule

`default_nettype wire

>>> tb/sv/pmu_counter_mux_assigner_checker.sv
// ----------------------------------------------------------------------------
// pmu_counter_mux_assigner_checker
// Watches the event and result channels of the mux assigner, predicts the
// result of every closed event set and compares it field by field.
// ----------------------------------------------------------------------------
module pmu_counter_mux_assigner_checker #(
  parameter int SLOTS = 4
) (
  input  logic   clk,
  input  logic   rst,
  pmu_cma_in_if  events,
  pmu_cma_out_if results,
  output int     error_count,
  output int     pending,
  output int     checked_count,
  output int     rejected_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import pmu_cma_pkg::*;

  typedef struct packed {
    logic                          status;
    logic [WORD_W-1:0]             word;
    logic                          en_first;
    logic                          en_other;
    logic [NUM_CTR-1:0][CTR_W-1:0] ctr;
    logic [COUNT_W-1:0]            count;
  } set_outcome_t;

  set_outcome_t                      set_outcome_q[$];
  logic [NUM_CTR-1:0][EVENT_W-1:0]   held_events;
  int                                held_n;
  logic                              overflowed;

  initial begin
    error_count    = 0;
    pending        = 0;
    checked_count  = 0;
    rejected_count = 0;
    held_n         = 0;
    overflowed     = 1'b0;
    held_events    = '0;
  end

  // storage-subsystem select position from the low select bits
  function automatic int grs_pos(input logic [2:0] sel_lo);
    case (sel_lo)
      3'd0, 3'd1, 3'd2: return 46;
      3'd3, 3'd4, 3'd5: return 44;
      3'd6:             return 41;
      default:          return 39;
    endcase
  endfunction

  function automatic set_outcome_t assign_counters(
    input logic [NUM_CTR-1:0][EVENT_W-1:0] evs,
    input int                              n
  );
    set_outcome_t                    res;
    set_outcome_t                    rej;
    logic [WORD_W-1:0]               w;
    logic [NUM_CTR-1:0]              busy;
    logic [NUM_LANE-1:0][UNIT_W-1:0] lane_unit;
    logic [NUM_LANE-1:0]             lane_valid;
    logic [15:0]                     used;
    logic [EVENT_W-1:0]              e;
    logic [3:0]                      pc;
    logic [UNIT_W-1:0]               unit;
    logic [2:0]                      by;
    logic [SEL_W-1:0]                sel;
    int                              slot;
    int                              mux_cnt;
    bit                              found;

    rej        = '0;
    rej.status = 1'b1;
    res        = '0;
    w          = '0;
    busy       = '0;
    lane_unit  = '0;
    lane_valid = '0;
    used       = '0;

    // conflict pass
    for (int i = 0; i < n; i++) begin
      e  = evs[i];
      pc = e[23:20];
      if (pc != 0) begin
        if (pc > PC_MAX) return rej;
        if (busy[pc - 4'd1]) return rej;
        busy[pc - 4'd1] = 1'b1;
      end
      if (e[7]) begin
        unit = e[19:16];
        by   = e[14:12];
        if (unit > UNIT_MAX) return rej;
        if (unit == UNIT_ISU0_ALT) unit = UNIT_ISU0;
        if (by[2]) begin
          if (unit != UNIT_HI_BYTE) return rej;
          unit  = UNIT_HI_LANE;
          by[2] = 1'b0;
        end
        if (lane_valid[by[1:0]] && lane_unit[by[1:0]] != unit) return rej;
        lane_valid[by[1:0]] = 1'b1;
        lane_unit[by[1:0]]  = unit;
        used[unit]          = 1'b1;
      end
    end

    // isu0 goes over to the second mux when the first is needed elsewhere
    if (used[UNIT_ISU0] && (|{used[3:2], used[0]})) begin
      used[UNIT_ISU0_ALT] = 1'b1;
      used[UNIT_ISU0]     = 1'b0;
    end
    mux_cnt = 0;
    for (int u = 0; u < 4; u++) begin
      if (used[u]) begin
        if (mux_cnt != 0) return rej;
        mux_cnt++;
        w[63:62] = 2'(u);
      end
    end
    mux_cnt = 0;
    for (int u = 4; u < 8; u++) begin
      if (used[u]) begin
        if (mux_cnt != 0) return rej;
        mux_cnt++;
        w[61:60] = 2'(u);
      end
    end

    for (int l = 0; l < NUM_LANE; l++) begin
      if (lane_valid[l]) begin
        unit = lane_unit[l];
        if (unit == UNIT_ISU0 && used[UNIT_ISU0_ALT]) begin
          unit = UNIT_ISU0_ALT;
        end else if (unit == UNIT_HI_LANE) begin
          w[59 - l] = 1'b1;
        end
        w[54 - 2*l +: 2] = w[54 - 2*l +: 2] | unit[3:2];
      end
    end

    // assignment pass
    for (int i = 0; i < n; i++) begin
      e    = evs[i];
      pc   = e[23:20];
      unit = e[19:16];
      by   = e[14:12];
      sel  = e[6:0];
      if (pc == 0) begin
        found = 1'b0;
        slot  = 0;
        for (int c = 0; c < NUM_CTR; c++) begin
          if (!found && !busy[c]) begin
            slot  = c;
            found = 1'b1;
          end
        end
        if (!found) return rej;
        busy[slot] = 1'b1;
      end else begin
        slot = int'(pc) - 1;
        if (e[7] && by[1] &&
            (sel == SEL_ADDER_A || sel == SEL_ADDER_B || sel == SEL_ADDER_C))
          w[35 - slot] = 1'b1;
      end
      if (e[7] && unit == UNIT_GRS)
        w = w | (64'(e[10:8]) << grs_pos(sel[2:0]));
      if ((sel & SEL_TWEAK_MASK) == SEL_TWEAK_MATCH && by[0] != slot[1])
        sel = sel | SEL_ALT_LANE;
      w = w | (64'(sel) << (25 - 8*slot));
      res.ctr[i] = CTR_W'(slot);
    end

    res.word     = w;
    res.en_first = busy[0];
    res.en_other = |busy[3:1];
    return res;
  endfunction

  task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    set_outcome_t exp_out;
    set_outcome_t new_out;
    if (rst) begin
      held_n     = 0;
      overflowed = 1'b0;
      set_outcome_q.delete();
    end else begin
      if (results.valid && results.ready) begin
        if (set_outcome_q.size() == 0) begin
          $display("%0t: result beat with nothing pending, expected none, actual word %h",
                   $time, results.mux_control_word);
          error_count++;
        end else begin
          exp_out = set_outcome_q.pop_front();
          check_field("status", exp_out.status, results.status);
          check_field("mux_control_word", exp_out.word, results.mux_control_word);
          check_field("first_counter_cond_enable", exp_out.en_first,
                      results.first_counter_cond_enable);
          check_field("other_counters_cond_enable", exp_out.en_other,
                      results.other_counters_cond_enable);
          check_field("counter_for_event0", exp_out.ctr[0], results.counter_for_event0);
          check_field("counter_for_event1", exp_out.ctr[1], results.counter_for_event1);
          check_field("counter_for_event2", exp_out.ctr[2], results.counter_for_event2);
          check_field("counter_for_event3", exp_out.ctr[3], results.counter_for_event3);
          check_field("events_in_set", exp_out.count, results.events_in_set);
          checked_count++;
          if (exp_out.status) rejected_count++;
        end
      end
      if (events.valid && events.ready) begin
        if (held_n < SLOTS && held_n < NUM_CTR) begin
          held_events[held_n] = events.event_code;
          held_n++;
        end else begin
          overflowed = 1'b1;
        end
        if (events.last_event) begin
          if (overflowed) begin
            new_out        = '0;
            new_out.status = 1'b1;
          end else begin
            new_out = assign_counters(held_events, held_n);
          end
          new_out.count = COUNT_W'(held_n);
          set_outcome_q.push_back(new_out);
          held_n     = 0;
          overflowed = 1'b0;
        end
      end
    end
    pending = set_outcome_q.size();
  end

endmodule

>>> tb/sv/pmu_counter_mux_assigner_top_tb.sv
// ----------------------------------------------------------------------------
// pmu_counter_mux_assigner_top_tb
// Drives event sets into the mux assigner: a directed opening for the corner
// cases, then mostly coherent random sets with some noise and oversized sets,
// with random idling on both channels. Checking is done by the checker.
// ----------------------------------------------------------------------------
module pmu_counter_mux_assigner_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pmu_cma_pkg::*;

  localparam int EVENT_SLOTS = 4;
  localparam int RANDOM_BEATS = 900;
  localparam int CALM_FROM   = 760;

  logic clk = 1'b0;
  logic rst;

  pmu_cma_in_if  events_ch ();
  pmu_cma_out_if results_ch ();

  int  error_count;
  int  pending;
  int  checked_count;
  int  rejected_count;
  int  beats_sent;
  int  sets_sent;
  int  stall_left;
  bit  src_idle_on;
  bit  snk_idle_on;

  logic [NUM_LANE-1:0][UNIT_W-1:0] lane_pal;
  logic [NUM_LANE-1:0]             lane_hi;

  pmu_counter_mux_assigner_top #(.EVENT_SLOTS(EVENT_SLOTS)) u_top (
    .clk     (clk),
    .rst     (rst),
    .events  (events_ch),
    .results (results_ch)
  );

  pmu_counter_mux_assigner_checker #(.SLOTS(EVENT_SLOTS)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .events         (events_ch),
    .results        (results_ch),
    .error_count    (error_count),
    .pending        (pending),
    .checked_count  (checked_count),
    .rejected_count (rejected_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      results_ch.ready <= 1'b0;
      stall_left       <= stall_left - 1;
    end else if (snk_idle_on && $urandom_range(0, 5) == 0) begin
      results_ch.ready <= 1'b0;
      stall_left       <= $urandom_range(0, 2);
    end else begin
      results_ch.ready <= 1'b1;
    end
  end

  task automatic send_beat(input logic [EVENT_W-1:0] code, input bit last);
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      events_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    events_ch.valid      <= 1'b1;
    events_ch.event_code <= code;
    events_ch.last_event <= last;
    @(posedge clk);
    while (!(events_ch.valid && events_ch.ready)) @(posedge clk);
    @(negedge clk);
    beats_sent++;
    if (last) sets_sent++;
  endtask

  function automatic logic [SEL_W-1:0] pick_select();
    logic [SEL_W-1:0] sel;
    case ($urandom_range(0, 7))
      0: sel = SEL_ADDER_A;
      1: sel = SEL_ADDER_B;
      2: sel = SEL_ADDER_C;
      3, 4: sel = SEL_TWEAK_MATCH | (SEL_W'($urandom()) & ~SEL_TWEAK_MASK);
      default: sel = SEL_W'($urandom());
    endcase
    return sel;
  endfunction

  // lane owners for one set, chosen so that the two unit muxes can agree
  task automatic build_palette();
    logic [UNIT_W-1:0] grp_a;
    logic [UNIT_W-1:0] grp_b;
    bit                isu_move;
    isu_move = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 2))
      0:       grp_b = 4'd4;
      1:       grp_b = 4'd5;
      default: grp_b = UNIT_GRS;
    endcase
    grp_a = UNIT_W'($urandom_range(0, 3));
    for (int l = 0; l < NUM_LANE; l++) begin
      lane_hi[l] = 1'b0;
      case ($urandom_range(0, 3))
        0: lane_pal[l] = isu_move ? ($urandom_range(0, 1) ? UNIT_ISU0 : UNIT_ISU0_ALT)
                                  : grp_a;
        1: begin
          if (isu_move) begin
            case ($urandom_range(0, 2))
              0:       lane_pal[l] = 4'd0;
              1:       lane_pal[l] = 4'd2;
              default: lane_pal[l] = 4'd3;
            endcase
          end else begin
            lane_pal[l] = grp_b;
          end
        end
        2: lane_pal[l] = UNIT_W'($urandom_range(8, 12));
        default: begin
          lane_pal[l] = UNIT_HI_BYTE;
          lane_hi[l]  = 1'($urandom_range(0, 1));
        end
      endcase
    end
  endtask

  task automatic send_coherent_set(input int n);
    logic [EVENT_W-1:0] code;
    logic [NUM_CTR-1:0] taken;
    int                 lane;
    int                 pc;
    taken = '0;
    build_palette();
    for (int k = 0; k < n; k++) begin
      code = EVENT_W'($urandom());
      lane = $urandom_range(0, 3);
      if ($urandom_range(0, 9) < 7) begin
        code[7]     = 1'b1;
        code[19:16] = lane_pal[lane];
        code[14:12] = {lane_hi[lane], 2'(lane)};
      end else begin
        code[7] = 1'b0;
      end
      pc = $urandom_range(1, 4);
      if ($urandom_range(0, 19) == 0) begin
        code[23:20] = 4'($urandom());
      end else if ($urandom_range(0, 1) && !taken[pc-1]) begin
        taken[pc-1] = 1'b1;
        code[23:20] = 4'(pc);
      end else begin
        code[23:20] = 4'd0;
      end
      code[6:0] = pick_select();
      send_beat(code, k == n - 1);
    end
  endtask

  task automatic send_noise_set(input int n);
    logic [EVENT_W-1:0] code;
    for (int k = 0; k < n; k++) begin
      code = EVENT_W'($urandom());
      if ($urandom_range(0, 1)) code[23:20] = 4'($urandom_range(0, 4));
      send_beat(code, k == n - 1);
    end
  endtask

  initial begin
    rst                  = 1'b1;
    events_ch.valid      = 1'b0;
    events_ch.event_code = '0;
    events_ch.last_event = 1'b0;
    results_ch.ready     = 1'b0;
    stall_left           = 0;
    beats_sent           = 0;
    sets_sent            = 0;
    src_idle_on          = 1'b1;
    snk_idle_on          = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // all-zero and all-ones codes
    send_beat(24'h000000, 1'b1);
    send_beat(24'hffffff, 1'b1);
    // all four fixed counters, adder select, storage-subsystem select, lane tweak
    send_beat(24'h40007f, 1'b0);
    send_beat(24'h300040, 1'b0);
    send_beat(24'h200008, 1'b0);
    send_beat(24'h1725a8, 1'b1);
    // two events on the same fixed counter
    send_beat(24'h100000, 1'b0);
    send_beat(24'h100001, 1'b1);
    // isu0 moved to the second mux
    send_beat(24'h010080, 1'b0);
    send_beat(24'h021081, 1'b1);
    // a high and a low byte lane of unit 12
    send_beat(24'h0c5082, 1'b0);
    send_beat(24'h0c2083, 1'b1);
    // bus unit out of range
    send_beat(24'h0d0080, 1'b1);
    // high byte on a unit that has none
    send_beat(24'h034080, 1'b1);
    // unit 0 and another unit on one lane
    send_beat(24'h000080, 1'b0);
    send_beat(24'h080081, 1'b1);
    // two first-mux units
    send_beat(24'h000080, 1'b0);
    send_beat(24'h021080, 1'b1);
    // set longer than the store
    for (int k = 1; k <= 5; k++) send_beat(EVENT_W'(k), k == 5);

    while (beats_sent < RANDOM_BEATS) begin
      if (beats_sent >= CALM_FROM) begin
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
      end else begin
        src_idle_on = ($urandom_range(0, 4) != 0);
        snk_idle_on = ($urandom_range(0, 4) != 0);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: send_coherent_set($urandom_range(1, 4));
        7, 8:                send_noise_set($urandom_range(1, 6));
        default:             send_coherent_set($urandom_range(5, 8));
      endcase
    end
    events_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("covered %0d event beats in %0d sets", beats_sent, sets_sent);
    $display("compared %0d results, %0d of them rejected sets", checked_count,
             rejected_count);
    if (error_count == 0 && pending == 0) begin
      $display("pmu_counter_mux_assigner_top_tb: done, clean");
    end else begin
      $display("pmu_counter_mux_assigner_top_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("pmu_counter_mux_assigner_top_tb: done, errors");
    $finish;
  end

endmodule

>>> sim.f
sv/pmu_cma_pkg.sv
sv/pmu_cma_if.sv
sv/pmu_counter_mux_assigner_top.sv
tb/sv/pmu_counter_mux_assigner_checker.sv
tb/sv/pmu_counter_mux_assigner_top_tb.sv
